// ===== src/rumble_pulse_pattern_engine_unit_assert.svh =====
// Assertion macros for the rumble pulse engine checker
`ifndef RUMBLE_PULSE_PATTERN_ENGINE_UNIT_ASSERT_SVH
`define RUMBLE_PULSE_PATTERN_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define RPPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define RPPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define RPPE_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rppe_pkg.sv =====
package rppe_pkg;

    localparam int KEY_BITS = 10;

    localparam int OP_W    = 2;
    localparam int STR_W   = 8;
    localparam int CNT_W   = 8;
    localparam int GAP_W   = 8;
    localparam int LVL_W   = 21;
    localparam int TGT_W   = 20;
    localparam int ENV_W   = 20;
    localparam int SHIFT_W = 12;

    localparam int IN_FIELDS_W  = STR_W + CNT_W + GAP_W + KEY_BITS;
    localparam int S_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + ENV_W + 1 + CNT_W + 1;
    localparam int M_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W      = M_DATA_W - OUT_FIELDS_W;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUEUE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

    localparam logic CFG_MOTOR_ENABLE    = 1'b0;
    localparam logic CFG_RUMBLE_DISABLED = 1'b1;

    localparam logic [LVL_W-1:0] RAMP_STEP  = 21'h000AAA;
    localparam logic [LVL_W-1:0] DECAY_STEP = 21'h000375;
    localparam logic [LVL_W-1:0] LEVEL_CAP  = 21'h010000;
    localparam logic [ENV_W-1:0] LEVEL_MAX  = 20'hFFAA9;
    localparam logic [ENV_W-1:0] TARGET_MAX = 20'hFF000;

    typedef struct packed {
        logic [KEY_BITS-1:0] pressed_keys;
        logic [GAP_W-1:0]    gap_ticks;
        logic [CNT_W-1:0]    pulse_count;
        logic [STR_W-1:0]    intensity;
        logic [OP_W-1:0]     operation;
    } rppe_item_t;

    typedef struct packed {
        logic              pattern_accepted;
        logic [CNT_W-1:0]  pulses_pending;
        logic              pulse_active;
        logic [ENV_W-1:0]  envelope_level;
        logic              motor_on;
    } rppe_result_t;

    typedef struct packed {
        logic motor_enable;
        logic rumble_disabled;
        logic latch_clr;
    } rppe_ctrl_t;

endpackage

// ===== src/rppe_core.sv =====
module rppe_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  rppe_pkg::rppe_item_t item,
    input  rppe_pkg::rppe_ctrl_t ctrl,
    output rppe_pkg::rppe_result_t result
);
    import rppe_pkg::*;

    logic                ramp_reg,   ramp_next;
    logic [LVL_W-1:0]    level_reg,  level_next;
    logic [TGT_W-1:0]    target_reg, target_next;
    logic                latch_reg,  latch_next;
    logic [CNT_W-1:0]    qcount_reg, qcount_next;
    logic [GAP_W-1:0]    qgap_reg,   qgap_next;
    logic [GAP_W-1:0]    qdelay_reg, qdelay_next;
    logic [STR_W-1:0]    qstr_reg,   qstr_next;
    logic [KEY_BITS-1:0] rmask_reg,  rmask_next;
    logic [STR_W-1:0]    lstr_reg,   lstr_next;
    logic [CNT_W-1:0]    lcnt_reg,   lcnt_next;
    logic [GAP_W-1:0]    lgap_reg,   lgap_next;

    logic             accepted;
    logic [TGT_W-1:0] goal_q;
    logic [TGT_W-1:0] goal_i;
    logic             lock_clear;
    logic             locked;

    assign goal_q = {qstr_reg, {SHIFT_W{1'b0}}};
    assign goal_i = {item.intensity, {SHIFT_W{1'b0}}};

    always_comb begin
        ramp_next   = ramp_reg;
        level_next  = level_reg;
        target_next = target_reg;
        latch_next  = latch_reg;
        qcount_next = qcount_reg;
        qgap_next   = qgap_reg;
        qdelay_next = qdelay_reg;
        qstr_next   = qstr_reg;
        rmask_next  = rmask_reg;
        lstr_next   = lstr_reg;
        lcnt_next   = lcnt_reg;
        lgap_next   = lgap_reg;
        accepted    = 1'b0;
        lock_clear  = (rmask_reg != '0) && ((item.pressed_keys & rmask_reg) == '0);
        locked      = !lock_clear && (rmask_reg != '0) && (lstr_reg == item.intensity)
                      && (lcnt_reg == item.pulse_count) && (lgap_reg == item.gap_ticks);
        case (item.operation)
            OP_TICK: begin
                if (ramp_reg) begin
                    latch_next = ctrl.motor_enable;
                    level_next = level_reg + RAMP_STEP;
                    if (level_next >= {1'b0, target_reg}) begin
                        ramp_next = 1'b0;
                        if ({1'b0, target_reg} > LEVEL_CAP) begin
                            level_next = LEVEL_CAP;
                        end
                    end
                end else begin
                    latch_next = 1'b0;
                    level_next = (level_reg < DECAY_STEP) ? '0 : level_reg - DECAY_STEP;
                end
                if (!ramp_next && level_next == '0 && qcount_reg != '0) begin
                    if (qdelay_reg != '0) begin
                        qdelay_next = qdelay_reg - 8'd1;
                    end else begin
                        // ramp is idle here, so unless rumble is disabled the goal replaces the target
                        if (!ctrl.rumble_disabled) begin
                            target_next = goal_q;
                            ramp_next   = (goal_q != '0);
                        end
                        qcount_next = qcount_reg - 8'd1;
                        qdelay_next = qgap_reg;
                    end
                end
            end
            OP_QUEUE: begin
                if (item.pulse_count == '0) begin
                    qcount_next = '0;
                    qgap_next   = '0;
                    qdelay_next = '0;
                    qstr_next   = '0;
                    rmask_next  = '0;
                    lstr_next   = '0;
                    lcnt_next   = '0;
                    lgap_next   = '0;
                    accepted    = 1'b1;
                end else if (!locked) begin
                    lstr_next   = item.intensity;
                    lcnt_next   = item.pulse_count;
                    lgap_next   = item.gap_ticks;
                    rmask_next  = item.pressed_keys;
                    qcount_next = '0;
                    qgap_next   = '0;
                    qdelay_next = '0;
                    qstr_next   = '0;
                    if (!ctrl.rumble_disabled) begin
                        if (!ramp_reg || target_reg <= goal_i) begin
                            target_next = goal_i;
                        end
                        if (level_reg < {1'b0, target_next}) begin
                            ramp_next = 1'b1;
                        end
                    end
                    if (item.pulse_count > 8'd1) begin
                        qcount_next = item.pulse_count - 8'd1;
                        qgap_next   = item.gap_ticks;
                        qdelay_next = item.gap_ticks;
                        qstr_next   = item.intensity;
                    end
                    accepted = 1'b1;
                end
            end
            OP_CANCEL: begin
                latch_next  = 1'b0;
                ramp_next   = 1'b0;
                level_next  = '0;
                target_next = '0;
                qcount_next = '0;
                qgap_next   = '0;
                qdelay_next = '0;
                qstr_next   = '0;
                rmask_next  = '0;
                lstr_next   = '0;
                lcnt_next   = '0;
                lgap_next   = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_reg   <= 1'b0;
            level_reg  <= '0;
            target_reg <= '0;
            latch_reg  <= 1'b0;
            qcount_reg <= '0;
            qgap_reg   <= '0;
            qdelay_reg <= '0;
            qstr_reg   <= '0;
            rmask_reg  <= '0;
            lstr_reg   <= '0;
            lcnt_reg   <= '0;
            lgap_reg   <= '0;
        end else begin
            if (ctrl.latch_clr) begin
                latch_reg <= 1'b0;
            end else if (advance) begin
                latch_reg <= latch_next;
            end
            if (advance) begin
                ramp_reg   <= ramp_next;
                level_reg  <= level_next;
                target_reg <= target_next;
                qcount_reg <= qcount_next;
                qgap_reg   <= qgap_next;
                qdelay_reg <= qdelay_next;
                qstr_reg   <= qstr_next;
                rmask_reg  <= rmask_next;
                lstr_reg   <= lstr_next;
                lcnt_reg   <= lcnt_next;
                lgap_reg   <= lgap_next;
            end
        end
    end

    assign result.motor_on         = latch_next;
    assign result.envelope_level   = level_next[ENV_W-1:0];
    assign result.pulse_active     = ramp_next;
    assign result.pulses_pending   = qcount_next;
    assign result.pattern_accepted = accepted;

endmodule

// ===== src/rumble_pulse_pattern_engine_unit.sv =====
// Rumble motor pulse sequencer. Each input word is a tick, a pattern request or
// a cancel (operation on s_tuser) and yields exactly one result word. One word
// is taken per clock unless the output stalls; each result passes through the
// input register, then one pass of add/compare logic into the result register.
// Both registers stall together on m_tready. Configuration writes are taken at
// any time but must only be issued while no word is in flight; writing
// motor_enable also drops the motor latch.
module rumble_pulse_pattern_engine_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // intensity, pulse_count, gap_ticks, pressed_keys, zero pad
    input  logic [rppe_pkg::S_DATA_W-1:0] s_tdata,
    // operation
    input  logic [rppe_pkg::OP_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // motor_on, envelope_level, pulse_active, pulses_pending, pattern_accepted, zero pad
    output logic [rppe_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic                          cfg_wr_data
);
    import rppe_pkg::*;

    logic         in_valid_reg, in_valid_next;
    rppe_item_t   in_item_reg;
    logic         m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic         motor_enable_reg;
    logic         rumble_disabled_reg;
    logic         s_fire;
    logic         advance;
    rppe_ctrl_t   ctrl;
    rppe_result_t result;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign m_valid_next  = advance ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    assign ctrl.motor_enable    = motor_enable_reg;
    assign ctrl.rumble_disabled = rumble_disabled_reg;
    assign ctrl.latch_clr       = cfg_wr_en && (cfg_addr == CFG_MOTOR_ENABLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            m_valid_reg         <= 1'b0;
            motor_enable_reg    <= 1'b1;
            rumble_disabled_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MOTOR_ENABLE:    motor_enable_reg    <= cfg_wr_data;
                    CFG_RUMBLE_DISABLED: rumble_disabled_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.operation    <= s_tuser;
            in_item_reg.intensity    <= s_tdata[STR_W-1:0];
            in_item_reg.pulse_count  <= s_tdata[STR_W +: CNT_W];
            in_item_reg.gap_ticks    <= s_tdata[STR_W+CNT_W +: GAP_W];
            in_item_reg.pressed_keys <= s_tdata[STR_W+CNT_W+GAP_W +: KEY_BITS];
        end
        if (advance) begin
            m_data_reg <= {{M_PAD_W{1'b0}}, result};
        end
    end

    rppe_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .ctrl    (ctrl),
        .result  (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== src/rppe_checker.sv =====
`include "rumble_pulse_pattern_engine_unit_assert.svh"

module rppe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rppe_pkg::M_DATA_W-1:0] m_tdata
);
    import rppe_pkg::*;

    // no result word straight out of reset
    `RPPE_ASSERT_RST(a_rst_quiet, !aresetn, !m_tvalid, "result valid after reset")
    // stalled result word holds
    `RPPE_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result word dropped or changed while stalled")
    // envelope never overshoots the largest target by a full ramp step
    `RPPE_ASSERT_NOW(a_lvl_max, m_tvalid, m_tdata[ENV_W:1] <= LEVEL_MAX,
        "envelope level beyond ramp limit")
    // while ramping the level is still below the top target
    `RPPE_ASSERT_NOW(a_ramp_lvl, m_tvalid && m_tdata[ENV_W+1],
        m_tdata[ENV_W:1] < TARGET_MAX, "ramp active at or above top target")

endmodule

bind rumble_pulse_pattern_engine_unit rppe_checker u_rppe_checker (.*);
